// ----- src/gdf_pkg.sv -----
// ----------------------------------------------------------------------------
// gdf_pkg
// Shared types and constants of the gossip duplicate filter: transaction
// payloads, command and verdict codes, controller states and the
// controller-to-datapath command and status groups.
// ----------------------------------------------------------------------------
package gdf_pkg;

  localparam int unsigned SeenDepth = 1024;
  localparam int unsigned IdxW      = $clog2(SeenDepth);
  localparam int unsigned CntW      = $clog2(SeenDepth + 1);

  localparam int unsigned SigBytes     = 4627;
  localparam int unsigned HeaderBytes  = 256;
  localparam int unsigned RecordLimit  = 16384;
  localparam int unsigned PayloadLimit = RecordLimit - SigBytes - HeaderBytes;

  // command codes
  localparam logic [1:0] CmdReceive   = 2'd0;
  localparam logic [1:0] CmdOriginate = 2'd1;
  localparam logic [1:0] CmdSweep     = 2'd2;

  // verdict codes
  localparam logic [2:0] VerdictForward    = 3'd0;
  localparam logic [2:0] VerdictLastHop    = 3'd1;
  localparam logic [2:0] VerdictDuplicate  = 3'd2;
  localparam logic [2:0] VerdictExpired    = 3'd3;
  localparam logic [2:0] VerdictOriginated = 3'd4;
  localparam logic [2:0] VerdictTooLarge   = 3'd5;
  localparam logic [2:0] VerdictSwept      = 3'd6;

  typedef struct packed {
    logic [1:0]  command;
    logic [63:0] id_high;
    logic [63:0] id_low;
    logic [63:0] stamp;
    logic [7:0]  ttl_in;
    logic [7:0]  hops_in;
    logic [15:0] payload_length;
    logic [63:0] max_age;
  } in_t;

  typedef struct packed {
    logic [2:0]  verdict;
    logic [7:0]  ttl_out;
    logic [7:0]  hops_out;
    logic        recorded;
    logic [10:0] entries;
  } out_t;

  typedef struct packed {
    logic [63:0] id_high;
    logic [63:0] id_low;
    logic [63:0] stamp;
  } entry_t;

  typedef enum logic [1:0] {
    StIdle,
    StDecode,
    StScan,
    StFinish
  } state_e;

  // controller to datapath
  typedef struct packed {
    logic load;        // capture the input transaction
    logic scan_start;  // reset the scan pointers
    logic scan;        // walk the table one entry a cycle
    logic finish;      // commit the item and load the result register
  } ctrl_t;

  // datapath to controller
  typedef struct packed {
    logic [1:0] command;
    logic       scan_done;
  } status_t;

endpackage

// ----- src/gdf_datapath.sv -----
// ----------------------------------------------------------------------------
// gdf_datapath
// Seen-identifier table with its scan pointers, lookup compare, age test,
// in-place compaction for sweeps, and the result register.
// ----------------------------------------------------------------------------
module gdf_datapath (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  gdf_pkg::in_t    in_i,
  input  gdf_pkg::ctrl_t  ctrl_i,
  output gdf_pkg::status_t status_o,
  output gdf_pkg::out_t   out_o
);

  gdf_pkg::entry_t mem [gdf_pkg::SeenDepth];

  gdf_pkg::in_t    in_q;
  gdf_pkg::entry_t rdata_q;
  gdf_pkg::out_t   out_q, out_d;

  logic [gdf_pkg::CntW-1:0] count_q, count_d;
  logic [gdf_pkg::CntW-1:0] rd_addr_q, rd_addr_d;
  logic [gdf_pkg::CntW-1:0] wr_ptr_q, wr_ptr_d;
  logic                     pend_q, pend_d;
  logic                     match_q, match_d;

  logic                     rd_en;
  logic                     keep;
  logic                     hit;
  logic                     we;
  logic [gdf_pkg::IdxW-1:0] waddr;
  gdf_pkg::entry_t          wdata;
  logic                     store;
  logic                     room;
  logic [63:0]              age;

  assign room  = count_q < gdf_pkg::CntW'(gdf_pkg::SeenDepth);
  assign rd_en = ctrl_i.scan && (rd_addr_q < count_q) && !match_q;
  assign age   = in_q.stamp - rdata_q.stamp;
  assign keep  = age <= in_q.max_age;
  assign hit   = (rdata_q.id_high == in_q.id_high) && (rdata_q.id_low == in_q.id_low);

  assign status_o.command   = in_q.command;
  assign status_o.scan_done = match_q || (!pend_q && (rd_addr_q == count_q));

  always_comb begin
    rd_addr_d = rd_addr_q;
    wr_ptr_d  = wr_ptr_q;
    pend_d    = pend_q;
    match_d   = match_q;
    count_d   = count_q;
    out_d     = out_q;
    store     = 1'b0;
    we        = 1'b0;
    waddr     = wr_ptr_q[gdf_pkg::IdxW-1:0];
    wdata     = rdata_q;

    if (ctrl_i.scan_start) begin
      rd_addr_d = '0;
      wr_ptr_d  = '0;
      pend_d    = 1'b0;
      match_d   = 1'b0;
    end

    if (ctrl_i.scan) begin
      pend_d = rd_en;
      if (rd_en) begin
        rd_addr_d = rd_addr_q + 1'b1;
      end
      if (pend_q) begin
        if (in_q.command == gdf_pkg::CmdReceive) begin
          if (hit) begin
            match_d = 1'b1;
          end
        end else if (keep) begin
          // compaction: write index never passes the read index
          we       = 1'b1;
          wr_ptr_d = wr_ptr_q + 1'b1;
        end
      end
    end

    if (ctrl_i.finish) begin
      out_d = '0;
      unique case (in_q.command)
        gdf_pkg::CmdReceive: begin
          if (match_q) begin
            out_d.verdict = gdf_pkg::VerdictDuplicate;
          end else if (in_q.ttl_in == 8'd0) begin
            out_d.verdict = gdf_pkg::VerdictExpired;
          end else begin
            store            = 1'b1;
            out_d.ttl_out    = in_q.ttl_in - 8'd1;
            out_d.hops_out   = (in_q.hops_in == 8'hFF) ? 8'hFF : in_q.hops_in + 8'd1;
            out_d.verdict    = (in_q.ttl_in != 8'd1) ? gdf_pkg::VerdictForward
                                                     : gdf_pkg::VerdictLastHop;
          end
        end
        gdf_pkg::CmdOriginate: begin
          if (in_q.payload_length > 16'(gdf_pkg::PayloadLimit)) begin
            out_d.verdict = gdf_pkg::VerdictTooLarge;
          end else begin
            store         = 1'b1;
            out_d.verdict = gdf_pkg::VerdictOriginated;
          end
        end
        gdf_pkg::CmdSweep: begin
          count_d       = wr_ptr_q;
          out_d.verdict = gdf_pkg::VerdictSwept;
        end
        default: begin
          out_d.verdict = gdf_pkg::VerdictSwept;
        end
      endcase

      if (store && room) begin
        we             = 1'b1;
        waddr          = count_q[gdf_pkg::IdxW-1:0];
        wdata.id_high  = in_q.id_high;
        wdata.id_low   = in_q.id_low;
        wdata.stamp    = in_q.stamp;
        count_d        = count_q + 1'b1;
        out_d.recorded = 1'b1;
      end
      out_d.entries = 11'(count_d);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q   <= '0;
      rd_addr_q <= '0;
      wr_ptr_q  <= '0;
      pend_q    <= 1'b0;
      match_q   <= 1'b0;
    end else begin
      count_q   <= count_d;
      rd_addr_q <= rd_addr_d;
      wr_ptr_q  <= wr_ptr_d;
      pend_q    <= pend_d;
      match_q   <= match_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.load) begin
      in_q <= in_i;
    end
    out_q <= out_d;
  end

  // table: one write and one registered read a cycle
  always_ff @(posedge clk_i) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (rd_en) begin
      rdata_q <= mem[rd_addr_q[gdf_pkg::IdxW-1:0]];
    end
  end

  assign out_o = out_q;

endmodule

// ----- src/gdf_controller.sv -----
// ----------------------------------------------------------------------------
// gdf_controller
// Sequencer of the filter: takes one transaction, runs the table scan when
// the command needs one, and hands the result to the output register.
// ----------------------------------------------------------------------------
module gdf_controller (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  input  gdf_pkg::status_t status_i,
  output gdf_pkg::ctrl_t   ctrl_o
);

  gdf_pkg::state_e state_q, state_d;
  logic            out_valid_q, out_valid_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= gdf_pkg::StIdle;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    ctrl_o     = '0;
    in_ready_o = 1'b0;

    unique case (state_q)
      gdf_pkg::StIdle: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          ctrl_o.load = 1'b1;
          state_d     = gdf_pkg::StDecode;
        end
      end
      gdf_pkg::StDecode: begin
        unique case (status_i.command)
          gdf_pkg::CmdReceive, gdf_pkg::CmdSweep: begin
            ctrl_o.scan_start = 1'b1;
            state_d           = gdf_pkg::StScan;
          end
          gdf_pkg::CmdOriginate: begin
            state_d = gdf_pkg::StFinish;
          end
          default: begin
            // unknown command: dropped without a result
            state_d = gdf_pkg::StIdle;
          end
        endcase
      end
      gdf_pkg::StScan: begin
        ctrl_o.scan = 1'b1;
        if (status_i.scan_done) begin
          state_d = gdf_pkg::StFinish;
        end
      end
      gdf_pkg::StFinish: begin
        // wait until the result register is free
        if (!out_valid_q || out_ready_i) begin
          ctrl_o.finish = 1'b1;
          state_d       = gdf_pkg::StIdle;
        end
      end
      default: begin
        state_d = gdf_pkg::StIdle;
      end
    endcase

    if (ctrl_o.finish) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

// ----- src/gossip_duplicate_filter.sv -----
// ----------------------------------------------------------------------------
// gossip_duplicate_filter
// Duplicate suppression with hop limit: a table of seen 128-bit message ids
// with stamps, looked up on receive, appended on receive and originate,
// compacted by age on sweep.
// ----------------------------------------------------------------------------
// sequence: originate goes through decode and finish; receive and sweep also
//   walk the stored entries (up to 1024) at one entry per cycle over the single
//   read port, a receive stopping at the first match
// throughput: one transaction at a time; a new one is taken while the last
//   result still waits in the output register
// reset: entry count cleared at once, table contents left undefined
module gossip_duplicate_filter (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  input  gdf_pkg::in_t  in_i,
  output logic          out_valid_o,
  input  logic          out_ready_i,
  output gdf_pkg::out_t out_o
);

  gdf_pkg::ctrl_t   ctrl;
  gdf_pkg::status_t status;

  gdf_controller u_controller (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .status_i    (status),
    .ctrl_o      (ctrl)
  );

  gdf_datapath u_datapath (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .in_i     (in_i),
    .ctrl_i   (ctrl),
    .status_o (status),
    .out_o    (out_o)
  );

  // one transaction in flight
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("transaction accepted while another is in progress");

  // rejected items never store an id
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (out_o.verdict == gdf_pkg::VerdictDuplicate ||
                    out_o.verdict == gdf_pkg::VerdictExpired ||
                    out_o.verdict == gdf_pkg::VerdictTooLarge ||
                    out_o.verdict == gdf_pkg::VerdictSwept)
    |-> !out_o.recorded && out_o.ttl_out == 8'd0)
    else $error("rejected item reported as recorded");

  // the entry count never passes the table depth
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> out_o.entries <= 11'(gdf_pkg::SeenDepth))
    else $error("entry count beyond table depth");

  // a pending result is not overwritten
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctrl.finish |-> !out_valid_o || out_ready_i)
    else $error("result register loaded while occupied");

endmodule

// ----- test/gossip_duplicate_filter_test.sv -----
// ----------------------------------------------------------------------------
// gossip_duplicate_filter_test
// Self-checking bench for the duplicate filter. Each accepted transaction is
// run through a behavioral copy of the seen-id table, and the expected
// verdict, if any, is queued. Every result is compared field by field with the
// oldest queued one. Directed tests come first: receive, originate, sweep and a
// full table. A long random run with random stalls on both sides follows.
// ----------------------------------------------------------------------------
module gossip_duplicate_filter_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [1:0]  CmdUnused   = 2'd3;
  localparam int unsigned DrainCycles = gdf_pkg::SeenDepth + 64;

  logic          clk;
  logic          rst_n     = 1'b0;
  logic          in_valid  = 1'b0;
  gdf_pkg::in_t  in_data   = '0;
  logic          in_ready;
  logic          out_valid;
  logic          out_ready = 1'b0;
  gdf_pkg::out_t out_data;

  bit            idle_on        = 1'b1;
  int unsigned   mismatch_count = 0;
  gdf_pkg::out_t expected_verdicts[$];

  // behavioral copy of the seen-id table
  gdf_pkg::entry_t seen_tab [gdf_pkg::SeenDepth];
  int unsigned     seen_cnt = 0;
  logic [127:0]    recent_ids[$];
  logic [63:0]     now_ns;

  gossip_duplicate_filter uut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .in_i        (in_data),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .out_o       (out_data)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  function automatic logic store_id(input gdf_pkg::in_t msg);
    if (seen_cnt >= gdf_pkg::SeenDepth) return 1'b0;
    seen_tab[seen_cnt] = {msg.id_high, msg.id_low, msg.stamp};
    seen_cnt++;
    return 1'b1;
  endfunction

  // returns 0 when the transaction produces no result
  function automatic bit predict_verdict(input gdf_pkg::in_t msg, output gdf_pkg::out_t res);
    logic        hit;
    logic [63:0] age;
    int unsigned keep;
    res  = '0;
    hit  = 1'b0;
    keep = 0;
    case (msg.command)
      gdf_pkg::CmdReceive: begin
        for (int unsigned i = 0; i < seen_cnt; i++) begin
          if (seen_tab[i].id_high == msg.id_high && seen_tab[i].id_low == msg.id_low) hit = 1'b1;
        end
        if (hit) begin
          res.verdict = gdf_pkg::VerdictDuplicate;
        end else if (msg.ttl_in == 8'd0) begin
          res.verdict = gdf_pkg::VerdictExpired;
        end else begin
          res.recorded = store_id(msg);
          res.ttl_out  = msg.ttl_in - 8'd1;
          res.hops_out = (msg.hops_in == 8'hFF) ? 8'hFF : msg.hops_in + 8'd1;
          res.verdict  = (res.ttl_out != 8'd0) ? gdf_pkg::VerdictForward
                                               : gdf_pkg::VerdictLastHop;
        end
      end
      gdf_pkg::CmdOriginate: begin
        if (32'(msg.payload_length) > gdf_pkg::PayloadLimit) begin
          res.verdict = gdf_pkg::VerdictTooLarge;
        end else begin
          res.recorded = store_id(msg);
          res.verdict  = gdf_pkg::VerdictOriginated;
        end
      end
      gdf_pkg::CmdSweep: begin
        // age wraps modulo 2^64
        for (int unsigned r = 0; r < seen_cnt; r++) begin
          age = msg.stamp - seen_tab[r].stamp;
          if (age <= msg.max_age) begin
            seen_tab[keep] = seen_tab[r];
            keep++;
          end
        end
        seen_cnt    = keep;
        res.verdict = gdf_pkg::VerdictSwept;
      end
      default: return 1'b0;
    endcase
    res.entries = 11'(seen_cnt);
    return 1'b1;
  endfunction

  function automatic gdf_pkg::in_t rand_item();
    gdf_pkg::in_t m;
    m.command        = 2'($urandom_range(0, 2));
    m.id_high        = {$urandom, $urandom};
    m.id_low         = {$urandom, $urandom};
    m.stamp          = {$urandom, $urandom};
    m.ttl_in         = 8'($urandom);
    m.hops_in        = 8'($urandom);
    m.payload_length = 16'($urandom);
    m.max_age        = {$urandom, $urandom};
    return m;
  endfunction

  task automatic push_message(input gdf_pkg::in_t msg);
    gdf_pkg::out_t res;
    if (idle_on && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 10)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= msg;
    do @(posedge clk); while (!in_ready);
    if (predict_verdict(msg, res)) expected_verdicts.push_back(res);
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    do @(posedge clk); while (expected_verdicts.size() != 0);
  endtask

  task automatic field_cmp(input string name, input logic [10:0] want, input logic [10:0] got);
    if (got !== want) begin
      mismatch_count++;
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
    end
  endtask

  task automatic check_result(input gdf_pkg::out_t got);
    gdf_pkg::out_t want;
    if (expected_verdicts.size() == 0) begin
      mismatch_count++;
      $display("%0t: unexpected result, expected none, actual %h", $time, got);
      return;
    end
    want = expected_verdicts.pop_front();
    field_cmp("verdict", 11'(want.verdict), 11'(got.verdict));
    field_cmp("ttl_out", 11'(want.ttl_out), 11'(got.ttl_out));
    field_cmp("hops_out", 11'(want.hops_out), 11'(got.hops_out));
    field_cmp("recorded", 11'(want.recorded), 11'(got.recorded));
    field_cmp("entries", want.entries, got.entries);
  endtask

  initial begin : result_monitor
    int unsigned stall;
    stall = 0;
    forever begin
      @(posedge clk);
      if (out_valid && out_ready) check_result(out_data);
      if (stall != 0) begin
        stall--;
        out_ready <= 1'b0;
      end else if (idle_on && $urandom_range(0, 5) == 0) begin
        stall = $urandom_range(0, 9);
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  task automatic clear_table();
    gdf_pkg::in_t m;
    while (seen_cnt != 0) begin
      m         = rand_item();
      m.command = gdf_pkg::CmdSweep;
      m.max_age = '0;
      push_message(m);
    end
  endtask

  task automatic test_receive_paths();
    gdf_pkg::in_t m;
    m         = rand_item();
    m.command = gdf_pkg::CmdReceive;
    m.id_high = 64'h0123_4567_89AB_CDEF;
    m.id_low  = 64'hFEDC_BA98_7654_3210;
    m.stamp   = 64'd100;
    m.ttl_in  = 8'd255;
    m.hops_in = 8'd0;
    push_message(m);
    push_message(m);
    // only the upper half matches, so this one is new
    m.id_low  = ~m.id_low;
    m.stamp   = 64'd200;
    m.ttl_in  = 8'd1;
    m.hops_in = 8'hFF;
    push_message(m);
    m.id_low  = 64'h1;
    m.ttl_in  = 8'd0;
    push_message(m);
    m.id_high = '0;
    m.id_low  = '0;
    m.stamp   = '0;
    m.ttl_in  = 8'd2;
    m.hops_in = 8'd254;
    push_message(m);
    m.id_high = '1;
    m.id_low  = '1;
    m.stamp   = '1;
    m.ttl_in  = 8'd128;
    m.hops_in = 8'd127;
    push_message(m);
    m         = rand_item();
    m.command = CmdUnused;
    push_message(m);
  endtask

  task automatic test_originate_paths();
    gdf_pkg::in_t m;
    m                = rand_item();
    m.command        = gdf_pkg::CmdOriginate;
    m.stamp          = 64'd400;
    m.payload_length = 16'(gdf_pkg::PayloadLimit);
    push_message(m);
    m.payload_length = 16'(gdf_pkg::PayloadLimit + 1);
    push_message(m);
    m.payload_length = 16'hFFFF;
    push_message(m);
    // known id is stored again on originate
    m.id_high        = '1;
    m.id_low         = '1;
    m.stamp          = 64'd500;
    m.payload_length = 16'd0;
    push_message(m);
    m.command        = gdf_pkg::CmdReceive;
    m.ttl_in         = 8'd9;
    push_message(m);
  endtask

  task automatic test_sweep_paths();
    gdf_pkg::in_t m;
    wait_drained();
    m         = rand_item();
    m.command = gdf_pkg::CmdSweep;
    m.stamp   = 64'd1000;
    m.max_age = '1;
    push_message(m);
    // stamps ahead of now wrap to huge ages
    m.stamp   = 64'd50;
    m.max_age = 64'd1000;
    push_message(m);
    m.stamp   = 64'd0;
    m.max_age = 64'd0;
    push_message(m);
    m.stamp   = 64'd7;
    push_message(m);
    m         = rand_item();
    m.command = gdf_pkg::CmdSweep;
    push_message(m);
  endtask

  task automatic test_table_full();
    gdf_pkg::in_t m;
    clear_table();
    while (seen_cnt < gdf_pkg::SeenDepth) begin
      m                = rand_item();
      m.command        = gdf_pkg::CmdOriginate;
      m.id_high        = {32'hF111_0000, 32'(seen_cnt)};
      m.id_low         = {32'h5EED_0000, 32'(seen_cnt)};
      m.stamp          = 64'(seen_cnt);
      m.payload_length = 16'($urandom_range(0, gdf_pkg::PayloadLimit));
      push_message(m);
    end
    // no room left: same verdicts, nothing recorded
    push_message(m);
    m         = rand_item();
    m.command = gdf_pkg::CmdReceive;
    m.ttl_in  = 8'd5;
    push_message(m);
    m.id_low  = ~m.id_low;
    m.ttl_in  = 8'd1;
    push_message(m);
    m.id_low  = m.id_low + 64'd1;
    m.ttl_in  = 8'd0;
    push_message(m);
    m.id_high = {32'hF111_0000, 32'd7};
    m.id_low  = {32'h5EED_0000, 32'd7};
    m.ttl_in  = 8'd3;
    push_message(m);
    m         = rand_item();
    m.command = gdf_pkg::CmdSweep;
    m.stamp   = 64'd1023;
    m.max_age = 64'd511;
    push_message(m);
    clear_table();
  endtask

  task automatic test_random(input int unsigned count);
    gdf_pkg::in_t m;
    int unsigned  done_items;
    int unsigned  kind;
    done_items = 0;
    // start close to the top so stamps wrap during the run
    now_ns = 64'hFFFF_FFFF_FFFF_FFFF - 64'($urandom_range(0, 20000));
    while (done_items < count) begin
      if (count - done_items <= 60) idle_on = 1'b0;
      now_ns += 64'($urandom_range(1, 100));
      m       = rand_item();
      m.stamp = now_ns;
      kind    = $urandom_range(0, 99);
      if (seen_cnt > 160) begin
        // keep the table walk short
        m.command = gdf_pkg::CmdSweep;
        m.max_age = 64'($urandom_range(0, 3000));
      end else if (kind < 45) begin
        m.command = gdf_pkg::CmdReceive;
        if (recent_ids.size() != 0 && $urandom_range(0, 2) == 0) begin
          {m.id_high, m.id_low} = recent_ids[$urandom_range(0, recent_ids.size() - 1)];
        end
        case ($urandom_range(0, 3))
          0: m.ttl_in = 8'd0;
          1: m.ttl_in = 8'd1;
          default: ;
        endcase
        if ($urandom_range(0, 7) == 0) m.hops_in = 8'hFF;
      end else if (kind < 70) begin
        m.command = gdf_pkg::CmdOriginate;
        if (recent_ids.size() != 0 && $urandom_range(0, 4) == 0) begin
          {m.id_high, m.id_low} = recent_ids[$urandom_range(0, recent_ids.size() - 1)];
        end
        case ($urandom_range(0, 3))
          0: m.payload_length = 16'(gdf_pkg::PayloadLimit - 2 + $urandom_range(0, 4));
          1, 2: m.payload_length = 16'($urandom_range(0, gdf_pkg::PayloadLimit));
          default: ;
        endcase
      end else if (kind < 80) begin
        m.command = gdf_pkg::CmdSweep;
        case ($urandom_range(0, 3))
          0: m.max_age = '1;
          1: m.max_age = {$urandom, $urandom};
          default: m.max_age = 64'($urandom_range(0, 5000));
        endcase
      end else if (kind < 85) begin
        m.command = CmdUnused;
      end else begin
        m.stamp = {$urandom, $urandom};
      end
      if (m.command == gdf_pkg::CmdReceive || m.command == gdf_pkg::CmdOriginate) begin
        recent_ids.push_back({m.id_high, m.id_low});
        if (recent_ids.size() > 32) void'(recent_ids.pop_front());
      end
      push_message(m);
      if (m.command != CmdUnused) done_items++;
      if ($urandom_range(0, 99) == 0) wait_drained();
    end
  endtask

  initial begin : test_sequence
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    test_receive_paths();
    test_originate_paths();
    test_sweep_paths();
    test_table_full();
    test_random(580);
    wait_drained();
    repeat (DrainCycles) @(posedge clk);
    if (mismatch_count == 0 && expected_verdicts.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

  initial begin : watchdog
    #4_000_000;
    $display("CHECKS FAILED");
    $finish;
  end

endmodule
